>>> sv/imu_fifo_frame_parser_top_assert.svh
`ifndef IMU_FIFO_FRAME_PARSER_TOP_ASSERT_SVH
`define IMU_FIFO_FRAME_PARSER_TOP_ASSERT_SVH

// invariant checked on every clock edge outside reset
`define IFP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence in the cycle after the trigger
`define IFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// consequence in the same cycle as the trigger
`define IFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/ifp_pkg.sv
package ifp_pkg;

    localparam int BYTE_W = 8;
    localparam int AXIS_W = 16;
    localparam int CNT_W  = 6;
    localparam int LEFT_W = 4;
    localparam int HOLD_W = 40;

    localparam int MAX_VECTORS_DEF = 32;

    typedef enum logic [2:0] {
        CFG_ACCEL     = 3'd0,
        CFG_GYRO      = 3'd1,
        CFG_SKIP      = 3'd2,
        CFG_TIME      = 3'd3,
        CFG_INPUT_CFG = 3'd4,
        CFG_DROP      = 3'd5
    } cfg_reg_t;

    typedef enum logic [5:0] {
        MODE_HEADER     = 6'b000001,
        MODE_GYRO       = 6'b000010,
        MODE_ACCEL      = 6'b000100,
        MODE_COMB_GYRO  = 6'b001000,
        MODE_COMB_ACCEL = 6'b010000,
        MODE_DISCARD    = 6'b100000
    } mode_t;

    typedef enum logic [1:0] {
        KIND_GYRO    = 2'd0,
        KIND_ACCEL   = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] accel;
        logic [BYTE_W-1:0] gyro;
        logic [BYTE_W-1:0] skip;
        logic [BYTE_W-1:0] stime;
        logic [BYTE_W-1:0] input_cfg;
        logic [BYTE_W-1:0] drop;
    } codes_t;

    typedef struct packed {
        mode_t             mode;
        logic [LEFT_W-1:0] bytes_left;
        logic [HOLD_W-1:0] hold;
        logic [CNT_W-1:0]  gyro_seen;
        logic [CNT_W-1:0]  accel_seen;
    } state_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
        logic [CNT_W-1:0]         gyro_total;
        logic [CNT_W-1:0]         accel_total;
        logic                     any_found;
        logic                     truncated;
        logic                     last_of_run;
    } res_t;

endpackage

>>> sv/ifp_if.sv
interface ifp_in_if;
    logic                       valid;
    logic                       ready;
    logic [ifp_pkg::BYTE_W-1:0] fifo_byte;
    logic                       block_end;

    modport source (output valid, output fifo_byte, output block_end, input ready);
    modport sink (input valid, input fifo_byte, input block_end, output ready);
endinterface

interface ifp_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic signed [ifp_pkg::AXIS_W-1:0] axis_x;
    logic signed [ifp_pkg::AXIS_W-1:0] axis_y;
    logic signed [ifp_pkg::AXIS_W-1:0] axis_z;
    logic [ifp_pkg::CNT_W-1:0]         gyro_total;
    logic [ifp_pkg::CNT_W-1:0]         accel_total;
    logic                              any_found;
    logic                              truncated;
    logic                              last_of_run;

    modport source (
        output valid, output kind, output axis_x, output axis_y, output axis_z,
        output gyro_total, output accel_total, output any_found, output truncated,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input axis_x, input axis_y, input axis_z,
        input gyro_total, input accel_total, input any_found, input truncated,
        input last_of_run, output ready
    );
endinterface

>>> sv/ifp_step.sv
module ifp_step #(
    parameter int MAX_VECTORS = ifp_pkg::MAX_VECTORS_DEF
) (
    input  ifp_pkg::state_t             cur,
    input  ifp_pkg::codes_t             codes,
    input  logic [ifp_pkg::BYTE_W-1:0]  fifo_byte,
    input  logic                        block_end,
    output ifp_pkg::state_t             nxt,
    output ifp_pkg::res_t               res0,
    output ifp_pkg::res_t               res1,
    output logic [1:0]                  res_count
);

    localparam int CW = ifp_pkg::CNT_W;
    localparam int LW = ifp_pkg::LEFT_W;
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_VECTORS);
    localparam logic [LW-1:0] VEC_LEFT  = LW'(6);
    localparam logic [LW-1:0] TIME_LEFT = LW'(3);
    localparam logic [LW-1:0] SHORT_LEFT = LW'(1);

    function automatic logic [ifp_pkg::AXIS_W-1:0] neg_sat(input logic [ifp_pkg::AXIS_W-1:0] v);
        if (v == 16'h8000)
        begin
            return 16'h7fff;
        end
        return 16'(-v);
    endfunction

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (c < MAX_CNT) ? c + CW'(1) : MAX_CNT;
    endfunction

    always_comb
    begin
        logic [LW-1:0]            left;
        logic                     vec_done;
        logic                     vec_gyro;
        logic [ifp_pkg::BYTE_W-1:0] comb_code;
        ifp_pkg::state_t          st;
        ifp_pkg::res_t            vec;
        ifp_pkg::res_t            sum;

        st        = cur;
        vec_done  = 1'b0;
        vec_gyro  = 1'b0;
        left      = (cur.bytes_left == '0) ? '0 : cur.bytes_left - LW'(1);
        comb_code = codes.accel | codes.gyro;

        unique case (cur.mode) inside
            ifp_pkg::MODE_GYRO, ifp_pkg::MODE_ACCEL,
            ifp_pkg::MODE_COMB_GYRO, ifp_pkg::MODE_COMB_ACCEL:
            begin
                if (left == '0)
                begin
                    vec_done = 1'b1;
                    vec_gyro = (cur.mode == ifp_pkg::MODE_GYRO) ||
                               (cur.mode == ifp_pkg::MODE_COMB_GYRO);
                    st.hold  = '0;
                    if (cur.mode == ifp_pkg::MODE_COMB_GYRO)
                    begin
                        st.mode       = ifp_pkg::MODE_COMB_ACCEL;
                        st.bytes_left = VEC_LEFT;
                    end
                    else
                    begin
                        st.mode       = ifp_pkg::MODE_HEADER;
                        st.bytes_left = '0;
                    end
                end
                else
                begin
                    st.hold       = {cur.hold[ifp_pkg::HOLD_W-9:0], fifo_byte};
                    st.bytes_left = left;
                end
            end
            ifp_pkg::MODE_DISCARD:
            begin
                st.bytes_left = left;
                if (left == '0)
                begin
                    st.mode = ifp_pkg::MODE_HEADER;
                end
            end
            default:
            begin
                st.hold = '0;
                if (fifo_byte == comb_code)
                begin
                    st.mode       = ifp_pkg::MODE_COMB_GYRO;
                    st.bytes_left = VEC_LEFT;
                end
                else if (fifo_byte == codes.gyro)
                begin
                    st.mode       = ifp_pkg::MODE_GYRO;
                    st.bytes_left = VEC_LEFT;
                end
                else if (fifo_byte == codes.accel)
                begin
                    st.mode       = ifp_pkg::MODE_ACCEL;
                    st.bytes_left = VEC_LEFT;
                end
                else if (fifo_byte == codes.skip || fifo_byte == codes.input_cfg ||
                         fifo_byte == codes.drop)
                begin
                    st.mode       = ifp_pkg::MODE_DISCARD;
                    st.bytes_left = SHORT_LEFT;
                end
                else if (fifo_byte == codes.stime)
                begin
                    st.mode       = ifp_pkg::MODE_DISCARD;
                    st.bytes_left = TIME_LEFT;
                end
                else
                begin
                    st.mode       = ifp_pkg::MODE_HEADER;
                    st.bytes_left = '0;
                end
            end
        endcase

        if (vec_done)
        begin
            if (vec_gyro)
            begin
                st.gyro_seen = bump(cur.gyro_seen);
            end
            else
            begin
                st.accel_seen = bump(cur.accel_seen);
            end
        end

        // hold carries payload bytes 0..4, oldest in the top byte
        vec.kind        = vec_gyro ? ifp_pkg::KIND_GYRO : ifp_pkg::KIND_ACCEL;
        vec.axis_x      = {cur.hold[31:24], cur.hold[39:32]};
        vec.axis_y      = neg_sat({cur.hold[15:8], cur.hold[23:16]});
        vec.axis_z      = neg_sat({fifo_byte, cur.hold[7:0]});
        vec.gyro_total  = '0;
        vec.accel_total = '0;
        vec.any_found   = 1'b0;
        vec.truncated   = 1'b0;
        vec.last_of_run = !block_end;

        sum.kind        = ifp_pkg::KIND_SUMMARY;
        sum.axis_x      = '0;
        sum.axis_y      = '0;
        sum.axis_z      = '0;
        sum.gyro_total  = st.gyro_seen;
        sum.accel_total = st.accel_seen;
        sum.any_found   = (st.gyro_seen != '0) || (st.accel_seen != '0);
        sum.truncated   = (st.mode != ifp_pkg::MODE_HEADER);
        sum.last_of_run = 1'b1;

        if (block_end)
        begin
            st.mode       = ifp_pkg::MODE_HEADER;
            st.bytes_left = '0;
            st.hold       = '0;
            st.gyro_seen  = '0;
            st.accel_seen = '0;
        end

        nxt       = st;
        res0      = vec_done ? vec : sum;
        res1      = sum;
        res_count = {1'b0, vec_done} + {1'b0, block_end};
    end

endmodule

>>> sv/imu_fifo_frame_parser_top.sv
// channel    modport  payload                                         accepted when
// fifo_ch    sink     fifo_byte, block_end                            valid && ready
// result_ch  source   kind, axis_x/y/z, totals, flags, last_of_run    valid && ready
//
// One byte is taken per cycle while fifo_ch.ready is high; the parser state updates at the accepting edge.
// Results enter a four-entry queue; the first one is on result_ch in the cycle after.
// fifo_ch.ready is low while three or more results wait in the queue.
// Reset restores the default header codes, header mode and an empty queue.
module imu_fifo_frame_parser_top #(
    parameter int MAX_VECTORS = ifp_pkg::MAX_VECTORS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    ifp_in_if.sink     fifo_ch,
    ifp_out_if.source  result_ch
);

`include "imu_fifo_frame_parser_top_assert.svh"

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    ifp_pkg::codes_t codes_reg;
    ifp_pkg::state_t state_reg;
    ifp_pkg::state_t state_next;
    ifp_pkg::res_t   res0;
    ifp_pkg::res_t   res1;
    logic [1:0]      res_count;

    ifp_pkg::res_t   q_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  wr_ptr_next;
    logic [QAW-1:0]  wr_ptr_inc;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QAW-1:0]  rd_ptr_next;
    logic [QCW-1:0]  count_reg;
    logic [QCW-1:0]  count_next;
    logic [1:0]      push_n;
    logic            accept;
    logic            pop;
    ifp_pkg::res_t   head;

    ifp_step #(
        .MAX_VECTORS (MAX_VECTORS)
    ) u_step (
        .cur       (state_reg),
        .codes     (codes_reg),
        .fifo_byte (fifo_ch.fifo_byte),
        .block_end (fifo_ch.block_end),
        .nxt       (state_next),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.accel     <= 8'd132;
            codes_reg.gyro      <= 8'd136;
            codes_reg.skip      <= 8'd64;
            codes_reg.stime     <= 8'd68;
            codes_reg.input_cfg <= 8'd72;
            codes_reg.drop      <= 8'd80;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ifp_pkg::CFG_ACCEL:     codes_reg.accel     <= cfg_data;
                ifp_pkg::CFG_GYRO:      codes_reg.gyro      <= cfg_data;
                ifp_pkg::CFG_SKIP:      codes_reg.skip      <= cfg_data;
                ifp_pkg::CFG_TIME:      codes_reg.stime     <= cfg_data;
                ifp_pkg::CFG_INPUT_CFG: codes_reg.input_cfg <= cfg_data;
                ifp_pkg::CFG_DROP:      codes_reg.drop      <= cfg_data;
                default:                ;
            endcase
        end
    end

    assign fifo_ch.ready = (count_reg <= QCW'(QDEPTH - 2));
    assign accept        = fifo_ch.valid && fifo_ch.ready;
    assign pop           = result_ch.valid && result_ch.ready;
    assign push_n        = accept ? res_count : 2'd0;

    assign wr_ptr_inc  = wr_ptr_reg + QAW'(1);
    assign wr_ptr_next = wr_ptr_reg + QAW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + QAW'(pop);
    assign count_next  = count_reg + QCW'(push_n) - QCW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= ifp_pkg::MODE_HEADER;
            state_reg.bytes_left <= '0;
            state_reg.hold       <= '0;
            state_reg.gyro_seen  <= '0;
            state_reg.accel_seen <= '0;
            wr_ptr_reg           <= '0;
            rd_ptr_reg           <= '0;
            count_reg            <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[wr_ptr_inc] <= res1;
        end
    end

    assign head = q_reg[rd_ptr_reg];

    assign result_ch.valid       = (count_reg != '0);
    assign result_ch.kind        = head.kind;
    assign result_ch.axis_x      = head.axis_x;
    assign result_ch.axis_y      = head.axis_y;
    assign result_ch.axis_z      = head.axis_z;
    assign result_ch.gyro_total  = head.gyro_total;
    assign result_ch.accel_total = head.accel_total;
    assign result_ch.any_found   = head.any_found;
    assign result_ch.truncated   = head.truncated;
    assign result_ch.last_of_run = head.last_of_run;

    `IFP_ASSERT_ALWAYS(a_queue_bound, count_reg <= QCW'(QDEPTH), "result queue overrun")
    `IFP_ASSERT_NEXT(a_stall_no_growth, !fifo_ch.ready, count_reg <= $past(count_reg),
        "queue grew while input stalled")
    `IFP_ASSERT_NEXT(a_burst_clears, accept && fifo_ch.block_end,
        state_reg.mode == ifp_pkg::MODE_HEADER && state_reg.gyro_seen == '0 &&
        state_reg.accel_seen == '0, "burst state not cleared after summary")
    `IFP_ASSERT_SAME(a_summary_last,
        result_ch.valid && result_ch.kind == ifp_pkg::KIND_SUMMARY,
        result_ch.last_of_run, "summary without last_of_run")

endmodule
